@@ hdl/ppl_pkg.sv @@
// Shared types for the polyline path length block.
// Used by ppl_sumsq, ppl_isqrt and polyline_path_length; no dependencies.
package ppl_pkg;

   localparam int unsigned COUNT_WIDTH = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PART_LL,
      PART_HL,
      PART_HH
   } part_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

@@ hdl/ppl_sumsq.sv @@
// Sum of squared coordinate differences, built from one half-width multiplier
// used nine times under a small counter. Depends on ppl_pkg.
module ppl_sumsq #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [COORD_WIDTH-1:0]        cur_x,
   input  logic [COORD_WIDTH-1:0]        cur_y,
   input  logic [COORD_WIDTH-1:0]        cur_z,
   input  logic [COORD_WIDTH-1:0]        prev_x,
   input  logic [COORD_WIDTH-1:0]        prev_y,
   input  logic [COORD_WIDTH-1:0]        prev_z,
   output ppl_pkg::unit_status_type      status,
   output logic [2*(COORD_WIDTH+1)-1:0]  radicand
);

   localparam int unsigned MW = COORD_WIDTH + 1;
   localparam int unsigned H  = (MW + 1) / 2;
   localparam int unsigned RW = 2 * MW;

   logic [MW-1:0]     mag_ff [3];
   logic [1:0]        axis_ff;
   ppl_pkg::part_type part_ff;
   logic              busy_ff;
   logic              pv_ff;
   logic              plast_ff;
   ppl_pkg::part_type psel_ff;
   logic [2*H-1:0]    prod_ff;
   logic [RW-1:0]     acc_ff;
   logic              done_ff;

   logic [MW-1:0]     dx, dy, dz;
   logic [MW-1:0]     cur_mag;
   logic [H-1:0]      lo_half, hi_half, op_a, op_b;
   logic [RW-1:0]     shifted;
   logic              last_issue;

   assign dx = {cur_x[COORD_WIDTH-1], cur_x} - {prev_x[COORD_WIDTH-1], prev_x};
   assign dy = {cur_y[COORD_WIDTH-1], cur_y} - {prev_y[COORD_WIDTH-1], prev_y};
   assign dz = {cur_z[COORD_WIDTH-1], cur_z} - {prev_z[COORD_WIDTH-1], prev_z};

   assign cur_mag = mag_ff[axis_ff];
   assign lo_half = cur_mag[H-1:0];
   assign hi_half = H'(cur_mag >> H);
   assign op_a    = (part_ff == ppl_pkg::PART_HH) ? hi_half : lo_half;
   assign op_b    = (part_ff == ppl_pkg::PART_LL) ? lo_half : hi_half;
   assign last_issue = (axis_ff == 2'd2) && (part_ff == ppl_pkg::PART_HH);

   always_comb begin
      unique case (psel_ff)
         ppl_pkg::PART_LL: shifted = RW'(prod_ff);
         ppl_pkg::PART_HL: shifted = RW'(prod_ff) << (H + 1);
         ppl_pkg::PART_HH: shifted = RW'(prod_ff) << (2 * H);
         default:          shifted = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pv_ff   <= busy_ff;
         done_ff <= pv_ff && plast_ff;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_issue) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff[0] <= dx[MW-1] ? (~dx + 1'b1) : dx;
         mag_ff[1] <= dy[MW-1] ? (~dy + 1'b1) : dy;
         mag_ff[2] <= dz[MW-1] ? (~dz + 1'b1) : dz;
         axis_ff   <= 2'd0;
         part_ff   <= ppl_pkg::PART_LL;
         acc_ff    <= '0;
      end else begin
         if (busy_ff) begin
            prod_ff  <= op_a * op_b;
            psel_ff  <= part_ff;
            plast_ff <= last_issue;
            unique case (part_ff)
               ppl_pkg::PART_LL: part_ff <= ppl_pkg::PART_HL;
               ppl_pkg::PART_HL: part_ff <= ppl_pkg::PART_HH;
               default: begin
                  part_ff <= ppl_pkg::PART_LL;
                  axis_ff <= axis_ff + 2'd1;
               end
            endcase
         end
         if (pv_ff) begin
            acc_ff <= acc_ff + shifted;
         end
      end
   end

   assign status.busy = busy_ff || pv_ff;
   assign status.done = done_ff;
   assign radicand    = acc_ff;

endmodule

@@ hdl/ppl_isqrt.sv @@
// Floor integer square root, two radicand bits per cycle, one root bit per cycle.
// Depends on ppl_pkg.
module ppl_isqrt #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2*(COORD_WIDTH+1)-1:0]  radicand,
   output ppl_pkg::unit_status_type      status,
   output logic [COORD_WIDTH:0]          root
);

   localparam int unsigned MW   = COORD_WIDTH + 1;
   localparam int unsigned RW   = 2 * MW;
   localparam int unsigned CNTW = $clog2(MW);

   logic [RW-1:0]   rad_ff;
   logic [MW:0]     rem_ff;
   logic [MW-1:0]   root_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   logic [MW+2:0]   rem_sh;
   logic [MW+2:0]   trial;
   logic            take;

   assign rem_sh = {rem_ff, rad_ff[RW-1:RW-2]};
   assign trial  = (MW + 3)'({root_ff, 2'b01});
   assign take   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNTW'(MW - 1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CNTW'(MW - 1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         cnt_ff  <= cnt_ff + 1'b1;
         rem_ff  <= take ? rem_sh[MW:0] - trial[MW:0] : rem_sh[MW:0];
         root_ff <= {root_ff[MW-2:0], take};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

@@ hdl/polyline_path_length.sv @@
// Top level: 3-D polyline path length with saturating accumulator.
// Depends on ppl_pkg, ppl_sumsq and ppl_isqrt.
//
//   port group  dir  handshake           payload
//   req_        in   req_valid/stall     point_x, point_y, point_z, last_point
//   rsp_        out  rsp_valid/stall     path_length, length_saturated, segments_summed
//   csr_        in   csr_valid/ready     start_index
//
// A point that adds a segment makes nine passes through the shared multiplier,
// then takes one cycle per root bit. A skipped or first point goes from ST_IDLE
// straight to ST_FINISH, with no square or root. Reset clears all trajectory state
// and start_index. A stalled result holds in its output register; the next
// point is taken meanwhile, and only a final point waits for it.
module polyline_path_length #(
   parameter int unsigned COORD_WIDTH  = 32,
   parameter int unsigned LENGTH_WIDTH = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [COORD_WIDTH-1:0]             req_point_x,
   input  logic [COORD_WIDTH-1:0]             req_point_y,
   input  logic [COORD_WIDTH-1:0]             req_point_z,
   input  logic                               req_last_point,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [LENGTH_WIDTH-1:0]            rsp_path_length,
   output logic                               rsp_length_saturated,
   output logic [ppl_pkg::COUNT_WIDTH-1:0]    rsp_segments_summed,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppl_pkg::COUNT_WIDTH-1:0]    csr_start_index
);

   localparam int unsigned MW = COORD_WIDTH + 1;
   localparam int unsigned SW = ((LENGTH_WIDTH > MW) ? LENGTH_WIDTH : MW) + 1;
   localparam int unsigned CW = ppl_pkg::COUNT_WIDTH;
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;
   localparam logic [CW-1:0]           COUNT_MAX  = '1;

   ppl_pkg::state_type           state_ff, state_in;
   logic [COORD_WIDTH-1:0]       prev_x_ff, prev_x_in;
   logic [COORD_WIDTH-1:0]       prev_y_ff, prev_y_in;
   logic [COORD_WIDTH-1:0]       prev_z_ff, prev_z_in;
   logic                         have_prev_ff, have_prev_in;
   logic [LENGTH_WIDTH-1:0]      acc_ff, acc_in;
   logic                         sat_ff, sat_in;
   logic [CW-1:0]                pc_ff, pc_in;
   logic [CW-1:0]                seg_ff, seg_in;
   logic [CW-1:0]                start_ff, start_in;
   logic                         last_ff, last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [LENGTH_WIDTH-1:0]      rsp_len_ff, rsp_len_in;
   logic                         rsp_sat_ff, rsp_sat_in;
   logic [CW-1:0]                rsp_seg_ff, rsp_seg_in;

   logic                         sq_start, root_start;
   ppl_pkg::unit_status_type     sq_status, root_status;
   logic [2*MW-1:0]              radicand;
   logic [MW-1:0]                root;
   logic [SW-1:0]                sum;
   logic                         sum_sat;

   ppl_sumsq #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_sumsq (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .cur_x    (req_point_x),
      .cur_y    (req_point_y),
      .cur_z    (req_point_z),
      .prev_x   (prev_x_ff),
      .prev_y   (prev_y_ff),
      .prev_z   (prev_z_ff),
      .status   (sq_status),
      .radicand (radicand)
   );

   ppl_isqrt #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .status   (root_status),
      .root     (root)
   );

   assign sum     = SW'(acc_ff) + SW'(root);
   assign sum_sat = sum >= SW'(LENGTH_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppl_pkg::ST_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         have_prev_ff <= 1'b0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         pc_ff        <= '0;
         seg_ff       <= '0;
         start_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_z_ff    <= prev_z_in;
         have_prev_ff <= have_prev_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         pc_ff        <= pc_in;
         seg_ff       <= seg_in;
         start_ff     <= start_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff <= rsp_len_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_seg_ff <= rsp_seg_in;
   end

   always_comb begin
      state_in     = state_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_z_in    = prev_z_ff;
      have_prev_in = have_prev_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      pc_in        = pc_ff;
      seg_in       = seg_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_len_in   = rsp_len_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_seg_in   = rsp_seg_ff;
      sq_start     = 1'b0;
      root_start   = 1'b0;

      if (csr_valid && csr_ready) begin
         start_in = csr_start_index;
      end

      unique case (state_ff)
         ppl_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_in  = req_last_point;
               state_in = ppl_pkg::ST_FINISH;
               if (pc_ff != COUNT_MAX) begin
                  pc_in = pc_ff + 1'b1;
               end
               if (pc_ff >= start_ff) begin
                  prev_x_in    = req_point_x;
                  prev_y_in    = req_point_y;
                  prev_z_in    = req_point_z;
                  have_prev_in = 1'b1;
                  if (have_prev_ff) begin
                     sq_start = 1'b1;
                     state_in = ppl_pkg::ST_SQUARE;
                  end
               end
            end
         end
         ppl_pkg::ST_SQUARE: begin
            if (sq_status.done) begin
               root_start = 1'b1;
               state_in   = ppl_pkg::ST_ROOT;
            end
         end
         ppl_pkg::ST_ROOT: begin
            if (root_status.done) begin
               acc_in   = sum_sat ? LENGTH_MAX : sum[LENGTH_WIDTH-1:0];
               sat_in   = sat_ff || sum_sat;
               state_in = ppl_pkg::ST_FINISH;
               if (seg_ff != COUNT_MAX) begin
                  seg_in = seg_ff + 1'b1;
               end
            end
         end
         ppl_pkg::ST_FINISH: begin
            if (!last_ff) begin
               state_in = ppl_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = acc_ff;
               rsp_sat_in   = sat_ff;
               rsp_seg_in   = seg_ff;
               prev_x_in    = '0;
               prev_y_in    = '0;
               prev_z_in    = '0;
               have_prev_in = 1'b0;
               acc_in       = '0;
               sat_in       = 1'b0;
               pc_in        = '0;
               seg_in       = '0;
               last_in      = 1'b0;
               state_in     = ppl_pkg::ST_IDLE;
            end
         end
         default: state_in = ppl_pkg::ST_IDLE;
      endcase
   end

   assign req_stall            = (state_ff != ppl_pkg::ST_IDLE);
   assign csr_ready            = (state_ff == ppl_pkg::ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_path_length      = rsp_len_ff;
   assign rsp_length_saturated = rsp_sat_ff;
   assign rsp_segments_summed  = rsp_seg_ff;

`ifndef ASSERT_OFF
   a_seg_le_points: assert property (@(posedge clock) disable iff (reset)
      seg_ff <= pc_ff)
      else $error("segment count exceeds point count");

   a_sat_holds_max: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (acc_ff == LENGTH_MAX))
      else $error("saturation flag set but length below maximum");

   a_no_prev_no_seg: assert property (@(posedge clock) disable iff (reset)
      !have_prev_ff |-> (seg_ff == '0) && (acc_ff == '0))
      else $error("length accumulated without a kept point");

   a_sq_in_state: assert property (@(posedge clock) disable iff (reset)
      (sq_status.busy || sq_status.done) |-> (state_ff == ppl_pkg::ST_SQUARE))
      else $error("square unit active outside its state");

   a_root_in_state: assert property (@(posedge clock) disable iff (reset)
      (root_status.busy || root_status.done) |-> (state_ff == ppl_pkg::ST_ROOT))
      else $error("root unit active outside its state");
`endif

endmodule
